// ===== src/bb3_pkg.sv =====
`timescale 1ns / 1ps
package bb3_pkg;

  localparam int MAX_SIDE = 1024;
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int COORD_W  = $clog2(MAX_SIDE);

  localparam int NUM_CH    = 3;
  localparam int CHAN_W    = 16;
  localparam int PIX_W     = NUM_CH * CHAN_W;
  localparam int COL_SUM_W = CHAN_W + 2;
  localparam int TOT_W     = CHAN_W + 4;

  // Channel lanes inside a pixel word
  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  // Reciprocals for the neighborhood sizes 9 and 6, exact for any TOT_W sum
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(1864136);
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(2796203);
  localparam int PROD_W = TOT_W + RECIP_W;

  // Neighborhood size codes
  localparam logic [1:0] CNT_9 = 2'd0;
  localparam logic [1:0] CNT_6 = 2'd1;
  localparam logic [1:0] CNT_4 = 2'd2;

  typedef logic [NUM_CH-1:0][CHAN_W-1:0] pixel_t;
  typedef logic [NUM_CH-1:0][TOT_W-1:0]  totals_t;

  // Item entering the window stage, registered when it is accepted
  typedef struct packed {
    logic               valid;
    logic               pixel;
    logic               emit;
    logic               last;
    logic [2:0]         col_use;
    logic [2:0]         row_use;
    logic [1:0]         cnt;
    logic [COORD_W-1:0] col;
    pixel_t             pix;
  } item_t;

  typedef struct packed {
    logic       emit;
    logic       last;
    logic [2:0] col_use;
    logic [2:0] row_use;
    logic [1:0] cnt;
  } win_tag_t;

  typedef struct packed {
    logic       emit;
    logic       last;
    logic [1:0] cnt;
  } sum_tag_t;

  typedef struct packed {
    logic               en;
    logic [COORD_W-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic               en;
    logic [COORD_W-1:0] addr;
    pixel_t             older;
    pixel_t             newer;
  } ram_wr_t;

endpackage

// ===== src/bb3_ram.sv =====
`timescale 1ns / 1ps
module bb3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/bb3_ctrl.sv =====
`timescale 1ns / 1ps
module bb3_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic                       func,
  input  bb3_pkg::pixel_t            in_pix,
  input  logic                       cfg_fire,
  input  logic [bb3_pkg::SIDE_W-1:0] side_length,
  output bb3_pkg::ram_rd_t           rd,
  output bb3_pkg::item_t             s1
);

  import bb3_pkg::*;

  logic [COORD_W-1:0] side_last;
  logic [COORD_W-1:0] irow, icol, orow, ocol;
  logic [COORD_W-1:0] irow_next, icol_next, orow_next, ocol_next;
  logic               frame_complete, frame_complete_next;
  logic [SIDE_W-1:0]  side_fix;
  logic               fire, pixel_mode, drain_mode, emit;
  logic               left, right, top, bottom;
  logic [1:0]         cnt;

  assign fire       = in_valid & adv;
  assign pixel_mode = ~frame_complete & ~func;
  assign drain_mode = frame_complete;
  assign emit = drain_mode |
                (pixel_mode & ((irow > COORD_W'(1)) |
                               ((irow == COORD_W'(1)) & (icol != '0))));

  assign left   = (ocol == '0);
  assign right  = (ocol == side_last);
  assign top    = (orow == '0);
  assign bottom = (orow == side_last);

  always_comb begin
    if ((left | right) & (top | bottom)) begin
      cnt = CNT_4;
    end else if (left | right | top | bottom) begin
      cnt = CNT_6;
    end else begin
      cnt = CNT_9;
    end
  end

  // Clamp the written side length into the supported range
  always_comb begin
    if (side_length < SIDE_W'(2)) begin
      side_fix = SIDE_W'(2);
    end else if (side_length > SIDE_W'(MAX_SIDE)) begin
      side_fix = SIDE_W'(MAX_SIDE);
    end else begin
      side_fix = side_length;
    end
  end

  always_comb begin
    irow_next           = irow;
    icol_next           = icol;
    orow_next           = orow;
    ocol_next           = ocol;
    frame_complete_next = frame_complete;
    if (pixel_mode) begin
      if (icol == side_last) begin
        icol_next = '0;
        if (irow == side_last) begin
          irow_next           = '0;
          frame_complete_next = 1'b1;
        end else begin
          irow_next = irow + COORD_W'(1);
        end
      end else begin
        icol_next = icol + COORD_W'(1);
      end
    end else if (drain_mode) begin
      // drain items walk the line stores for the bottom row
      icol_next = icol + COORD_W'(1);
    end
    if (emit) begin
      if (right & bottom) begin
        irow_next           = '0;
        icol_next           = '0;
        orow_next           = '0;
        ocol_next           = '0;
        frame_complete_next = 1'b0;
      end else if (right) begin
        ocol_next = '0;
        orow_next = orow + COORD_W'(1);
      end else begin
        ocol_next = ocol + COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_last      <= COORD_W'(1);
      irow           <= '0;
      icol           <= '0;
      orow           <= '0;
      ocol           <= '0;
      frame_complete <= 1'b0;
    end else if (cfg_fire) begin
      side_last      <= COORD_W'(side_fix - SIDE_W'(1));
      irow           <= '0;
      icol           <= '0;
      orow           <= '0;
      ocol           <= '0;
      frame_complete <= 1'b0;
    end else if (fire) begin
      irow           <= irow_next;
      icol           <= icol_next;
      orow           <= orow_next;
      ocol           <= ocol_next;
      frame_complete <= frame_complete_next;
    end
  end

  assign rd.en   = fire & (pixel_mode | drain_mode);
  assign rd.addr = icol;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s1.emit  <= 1'b0;
    end else if (adv) begin
      s1.valid <= fire & (pixel_mode | drain_mode);
      s1.emit  <= fire & emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1.pixel   <= pixel_mode;
      s1.last    <= right & bottom;
      s1.col_use <= right ? 3'b011 : (left ? 3'b110 : 3'b111);
      s1.row_use <= {~bottom, 1'b1, ~top};
      s1.cnt     <= cnt;
      s1.col     <= icol;
      s1.pix     <= in_pix;
    end
  end

  a_complete_row: assert property (@(posedge clk) disable iff (rst)
    frame_complete |-> (irow == '0))
    else $error("input row not cleared at end of frame");

  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    $rose(frame_complete) |->
      (orow == COORD_W'(side_last - COORD_W'(1))) && (ocol == side_last))
    else $error("output position wrong when the frame completes");

  a_output_lag: assert property (@(posedge clk) disable iff (rst)
    (!frame_complete && irow > COORD_W'(1)) |->
      (COORD_W'(orow + COORD_W'(1)) == irow) ||
      ((COORD_W'(orow + COORD_W'(2)) == irow) && (ocol == side_last)))
    else $error("output position does not trail input by one row");

endmodule

// ===== src/bb3_window.sv =====
`timescale 1ns / 1ps
module bb3_window (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  bb3_pkg::item_t    s1,
  input  bb3_pkg::pixel_t   older_rd,
  input  bb3_pkg::pixel_t   newer_rd,
  output bb3_pkg::ram_wr_t  wr,
  output bb3_pkg::sum_tag_t s4,
  output bb3_pkg::totals_t  s4_total
);

  import bb3_pkg::*;

  // win[column][row]: column 0 oldest, row 0 topmost
  pixel_t   win [3][3];
  win_tag_t s2;
  sum_tag_t s3;
  logic [NUM_CH-1:0][COL_SUM_W-1:0] colsum [3];
  logic [NUM_CH-1:0][COL_SUM_W-1:0] colsum_next [3];
  totals_t  total_next;

  // Rotate the column: newer row moves to older, the new pixel becomes newer
  assign wr.en    = adv & s1.valid & s1.pixel;
  assign wr.addr  = s1.col;
  assign wr.older = newer_rd;
  assign wr.newer = s1.pix;

  always_ff @(posedge clk) begin
    if (adv && s1.valid) begin
      win[0]    <= win[1];
      win[1]    <= win[2];
      win[2][0] <= older_rd;
      win[2][1] <= newer_rd;
      win[2][2] <= s1.pix;
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < NUM_CH; k++) begin
        colsum_next[j][k] = '0;
        for (int r = 0; r < 3; r++) begin
          if (s2.col_use[j] && s2.row_use[r]) begin
            colsum_next[j][k] = colsum_next[j][k] + COL_SUM_W'(win[j][r][k]);
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      total_next[k] = TOT_W'(colsum[0][k]) + TOT_W'(colsum[1][k]) + TOT_W'(colsum[2][k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.emit <= 1'b0;
      s3.emit <= 1'b0;
      s4.emit <= 1'b0;
    end else if (adv) begin
      s2.emit <= s1.emit;
      s3.emit <= s2.emit;
      s4.emit <= s3.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2.last    <= s1.last;
      s2.col_use <= s1.col_use;
      s2.row_use <= s1.row_use;
      s2.cnt     <= s1.cnt;
      s3.last    <= s2.last;
      s3.cnt     <= s2.cnt;
      colsum     <= colsum_next;
      s4.last    <= s3.last;
      s4.cnt     <= s3.cnt;
      s4_total   <= total_next;
    end
  end

endmodule

// ===== src/bb3_mean.sv =====
`timescale 1ns / 1ps
module bb3_mean (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  bb3_pkg::sum_tag_t           s4,
  input  bb3_pkg::totals_t            s4_total,
  output logic                        out_valid,
  output logic [bb3_pkg::CHAN_W-1:0]  out_red,
  output logic [bb3_pkg::CHAN_W-1:0]  out_green,
  output logic [bb3_pkg::CHAN_W-1:0]  out_blue,
  output logic                        frame_last
);

  import bb3_pkg::*;

  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod [NUM_CH];
  pixel_t             mean;

  assign recip = (s4.cnt == CNT_9) ? RECIP_9 : RECIP_6;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      prod[k] = PROD_W'(s4_total[k]) * PROD_W'(recip);
      case (s4.cnt)
        CNT_9:   mean[k] = prod[k][RECIP_SHIFT +: CHAN_W];
        CNT_6:   mean[k] = prod[k][RECIP_SHIFT +: CHAN_W];
        CNT_4:   mean[k] = s4_total[k][2 +: CHAN_W];
        default: mean[k] = s4_total[k][2 +: CHAN_W];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s4.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_red    <= mean[CH_RED];
      out_green  <= mean[CH_GREEN];
      out_blue   <= mean[CH_BLUE];
      frame_last <= s4.last;
    end
  end

endmodule

// ===== src/box_blur_three_by_three_top.sv =====
`timescale 1ns / 1ps
// 3x3 box blur of a square RGB image, 16 bits per channel.
// Input channel (in_valid / in_stall): one item per accepted edge. With
// func = 0 the item is the next pixel of the frame in raster order; once the
// frame's last pixel is in, every item (any func) releases one pending
// output, side_length + 1 of them. A drain item sent mid-frame is dropped.
// Output channel (out_valid / out_stall): the in-frame neighborhood mean of
// each pixel in raster order, truncated; frame_last marks the final one and
// the next pixel opens a new frame.
// Configuration (cfg_valid / cfg_ready, side_length): write only while idle;
// values are clamped to 2..1024 and the frame in progress is abandoned.
// Throughput: one item per cycle while not stalled, set by the single
// read-modify-write pass over the two line memories (one read and one write
// port each). Items pass s1, window, column-sum, total and output registers.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises in the same cycle.
// Reset: side length 2, counters cleared, no result pending; the line
// memories are not cleared and need not be.
module box_blur_three_by_three_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       func,
  input  logic [bb3_pkg::CHAN_W-1:0] in_red,
  input  logic [bb3_pkg::CHAN_W-1:0] in_green,
  input  logic [bb3_pkg::CHAN_W-1:0] in_blue,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bb3_pkg::CHAN_W-1:0] out_red,
  output logic [bb3_pkg::CHAN_W-1:0] out_green,
  output logic [bb3_pkg::CHAN_W-1:0] out_blue,
  output logic                       frame_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bb3_pkg::SIDE_W-1:0] side_length
);

  import bb3_pkg::*;

  logic     adv;
  pixel_t   in_pix;
  pixel_t   older_rd, newer_rd;
  ram_rd_t  rd;
  ram_wr_t  wr;
  item_t    s1;
  sum_tag_t s4;
  totals_t  s4_total;

  // Advance everything unless a finished result is held by the receiver
  assign adv       = ~out_valid | ~out_stall;
  assign in_stall  = ~adv;
  assign cfg_ready = 1'b1;

  assign in_pix[CH_RED]   = in_red;
  assign in_pix[CH_GREEN] = in_green;
  assign in_pix[CH_BLUE]  = in_blue;

  bb3_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (in_valid),
    .func        (func),
    .in_pix      (in_pix),
    .cfg_fire    (cfg_valid & cfg_ready),
    .side_length (side_length),
    .rd          (rd),
    .s1          (s1)
  );

  bb3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_SIDE)
  ) u_ram_older (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.older),
    .rd_en   (rd.en),
    .rd_addr (rd.addr),
    .rd_data (older_rd)
  );

  bb3_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_SIDE)
  ) u_ram_newer (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.newer),
    .rd_en   (rd.en),
    .rd_addr (rd.addr),
    .rd_data (newer_rd)
  );

  bb3_window u_window (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .s1       (s1),
    .older_rd (older_rd),
    .newer_rd (newer_rd),
    .wr       (wr),
    .s4       (s4),
    .s4_total (s4_total)
  );

  bb3_mean u_mean (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .s4         (s4),
    .s4_total   (s4_total),
    .out_valid  (out_valid),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .frame_last (frame_last)
  );

endmodule

// ===== sim/blur_mean_checker.sv =====
`timescale 1ns / 1ps
module blur_mean_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       func,
  input  logic [bb3_pkg::CHAN_W-1:0] in_red,
  input  logic [bb3_pkg::CHAN_W-1:0] in_green,
  input  logic [bb3_pkg::CHAN_W-1:0] in_blue,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [bb3_pkg::CHAN_W-1:0] out_red,
  input  logic [bb3_pkg::CHAN_W-1:0] out_green,
  input  logic [bb3_pkg::CHAN_W-1:0] out_blue,
  input  logic                       frame_last,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [bb3_pkg::SIDE_W-1:0] side_length,
  output int                         outstanding,
  output int                         mismatches
);

  import bb3_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
  } blurred_t;

  // Four most recent rows, indexed by row number modulo 4
  rgb_t        row_ring [4][MAX_SIDE];
  int unsigned side;
  int unsigned in_row;
  int unsigned in_col;
  int unsigned out_row;
  int unsigned out_col;
  bit          frame_full;
  blurred_t    blurred_q [$];
  int          bad;

  initial begin
    outstanding = 0;
    mismatches  = 0;
    bad         = 0;
  end

  function automatic void restart_frame();
    in_row     = 0;
    in_col     = 0;
    out_row    = 0;
    out_col    = 0;
    frame_full = 1'b0;
  endfunction

  // Average the in-frame neighborhood of the next output and advance.
  function automatic void emit_mean();
    int unsigned r0, r1, c0, c1, rr, cc, cnt, s_r, s_g, s_b;
    blurred_t    res;
    r0 = (out_row > 0) ? out_row - 1 : 0;
    r1 = (out_row + 1 < side) ? out_row + 1 : side - 1;
    c0 = (out_col > 0) ? out_col - 1 : 0;
    c1 = (out_col + 1 < side) ? out_col + 1 : side - 1;
    s_r = 0;
    s_g = 0;
    s_b = 0;
    cnt = 0;
    for (rr = r0; rr <= r1; rr++) begin
      for (cc = c0; cc <= c1; cc++) begin
        s_r += row_ring[rr % 4][cc].red;
        s_g += row_ring[rr % 4][cc].green;
        s_b += row_ring[rr % 4][cc].blue;
        cnt++;
      end
    end
    res.red   = CHAN_W'(s_r / cnt);
    res.green = CHAN_W'(s_g / cnt);
    res.blue  = CHAN_W'(s_b / cnt);
    res.last  = (out_row + 1 >= side) && (out_col + 1 >= side);
    blurred_q.push_back(res);
    if (res.last) begin
      restart_frame();
    end else if (out_col + 1 >= side) begin
      out_col = 0;
      out_row = out_row + 1;
    end else begin
      out_col = out_col + 1;
    end
  endfunction

  function automatic void take_item(input logic is_drain, input rgb_t px);
    int unsigned pos;
    if (frame_full) begin
      emit_mean();
    end else if (!is_drain) begin
      row_ring[in_row % 4][in_col] = px;
      pos = in_row * side + in_col;
      if (in_col + 1 >= side) begin
        in_col = 0;
        if (in_row + 1 >= side) begin
          in_row     = 0;
          frame_full = 1'b1;
        end else begin
          in_row = in_row + 1;
        end
      end else begin
        in_col = in_col + 1;
      end
      if (pos >= side + 1) emit_mean();
    end
  endfunction

  function automatic void check_field(input string name, input logic [CHAN_W-1:0] want,
                                      input logic [CHAN_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      bad++;
    end
  endfunction

  always @(posedge clk) begin
    blurred_t want;
    rgb_t     px;
    if (rst) begin
      side = 2;
      restart_frame();
      blurred_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (blurred_q.size() == 0) begin
          $error("unexpected result: out_red %0d out_green %0d out_blue %0d frame_last %0d",
                 out_red, out_green, out_blue, frame_last);
          bad++;
        end else begin
          want = blurred_q.pop_front();
          check_field("out_red", want.red, out_red);
          check_field("out_green", want.green, out_green);
          check_field("out_blue", want.blue, out_blue);
          check_field("frame_last", CHAN_W'(want.last), CHAN_W'(frame_last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (side_length < 2) side = 2;
        else if (side_length > MAX_SIDE) side = MAX_SIDE;
        else side = side_length;
        restart_frame();
      end
      if (in_valid && !in_stall) begin
        px.red   = in_red;
        px.green = in_green;
        px.blue  = in_blue;
        take_item(func, px);
      end
    end
    outstanding <= blurred_q.size();
    mismatches  <= bad;
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import bb3_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 850;
  localparam int PIPE_WAIT    = 12;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic              func        = 1'b0;
  logic [CHAN_W-1:0] in_red      = '0;
  logic [CHAN_W-1:0] in_green    = '0;
  logic [CHAN_W-1:0] in_blue     = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic              frame_last;
  logic              cfg_valid   = 1'b0;
  logic              cfg_ready;
  logic [SIDE_W-1:0] side_length = '0;
  int                outstanding;
  int                mismatches;

  bit          offering   = 1'b0;
  int          burst_left = 0;
  int unsigned cur_side   = 2;

  box_blur_three_by_three_top i_dut (.*);

  blur_mean_checker i_chk (.*);

  initial forever #6 clk = ~clk;

  function automatic logic [CHAN_W-1:0] chan_val();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  // Offer one item, hold it until taken, then maybe pause the burst.
  task automatic push_item(input logic is_drain, input logic [CHAN_W-1:0] r,
                           input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
    in_valid <= 1'b1;
    func     <= is_drain;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    offering = 1'b1;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 20);
    end
  endtask

  task automatic push_pixel();
    push_item(1'b0, chan_val(), chan_val(), chan_val());
  endtask

  task automatic push_any();
    push_item(1'($urandom_range(0, 1)), chan_val(), chan_val(), chan_val());
  endtask

  // Drop valid and wait until every predicted result has left the block.
  task automatic settle();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    do @(posedge clk); while (outstanding != 0);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  task automatic write_side(input int unsigned v);
    cfg_valid   <= 1'b1;
    side_length <= SIDE_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (v < 2) cur_side = 2;
    else if (v > MAX_SIDE) cur_side = MAX_SIDE;
    else cur_side = v;
  endtask

  // Receiver: stall pattern changes per segment, with long hold-offs.
  initial begin : receiver
    int seg_left, mode, taken, hold_left, holds;
    seg_left  = 0;
    mode      = 0;
    taken     = 0;
    hold_left = 0;
    holds     = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) taken++;
      if (hold_left == 0 && holds < 2 && taken >= 300 + holds * 900) begin
        hold_left = 600;
        holds++;
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 4);
        seg_left = $urandom_range(40, 200);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= 1'($urandom_range(0, 1));
          3:       out_stall <= ($urandom_range(0, 7) != 0);
          default: out_stall <= (seg_left % 3 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[box_blur_three_by_three_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    int          random_items, pick;
    int unsigned area, stop_at, k;
    bit          must_write;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset side of 2: early drain, extremes, a mid-frame drain, mixed tail
    push_item(1'b1, '1, '1, '1);
    push_item(1'b0, '0, '0, '0);
    push_item(1'b0, '1, '1, '1);
    push_item(1'b1, '0, '0, '0);
    push_item(1'b0, '1, '0, 16'd1);
    push_item(1'b0, 16'd1, '1, '0);
    push_item(1'b1, '0, '0, '0);
    push_item(1'b0, '1, '1, '1);
    push_item(1'b1, chan_val(), chan_val(), chan_val());
    settle();

    // Zero clamps up to 2; saturated frame
    write_side(0);
    repeat (4) push_item(1'b0, '1, '1, '1);
    repeat (3) push_any();
    settle();

    // Oversize write clamps to the maximum; abandon after a few pixels
    write_side(2047);
    repeat (20) push_pixel();
    settle();

    // Full-width rows: run past row one so some outputs leave, then abandon
    write_side(MAX_SIDE);
    repeat (MAX_SIDE + 9) push_pixel();
    settle();

    random_items = 0;
    must_write   = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      if (must_write || $urandom_range(0, 3) == 0) begin
        settle();
        pick = $urandom_range(0, 99);
        if (pick < 5) write_side($urandom_range(0, 1));
        else if (pick < 85) write_side($urandom_range(2, 8));
        else if (pick < 96) write_side($urandom_range(9, 16));
        else write_side($urandom_range(17, 24));
        must_write = 1'b0;
      end
      area    = cur_side * cur_side;
      stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, area - 1) : area;
      for (k = 0; k < stop_at; k++) begin
        if ($urandom_range(0, 19) == 0) push_item(1'b1, chan_val(), chan_val(), chan_val());
        push_pixel();
        random_items++;
      end
      if (stop_at < area) begin
        must_write = 1'b1;
      end else begin
        repeat (cur_side + 1) begin
          push_any();
          random_items++;
        end
      end
    end

    settle();
    repeat (PIPE_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("[box_blur_three_by_three_top] OK");
    end else begin
      $display("[box_blur_three_by_three_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/bb3_pkg.sv
src/bb3_ram.sv
src/bb3_ctrl.sv
src/bb3_window.sv
src/bb3_mean.sv
src/box_blur_three_by_three_top.sv
sim/blur_mean_checker.sv
sim/testbench.sv
